@@ src/grt_pkg.sv @@
// ----------------------------------------------------------------------------
// grt_pkg
// Shared types, codes and constants of the generational resource table.
// ----------------------------------------------------------------------------
package grt_pkg;

    localparam int unsigned ENTRIES_DEF       = 64;
    localparam int unsigned TIMELINE_BITS_DEF = 48;

    // operation codes
    localparam logic [2:0] FN_CREATE  = 3'd0;
    localparam logic [2:0] FN_UPDATE  = 3'd1;
    localparam logic [2:0] FN_TOUCH   = 3'd2;
    localparam logic [2:0] FN_DESTROY = 3'd3;
    localparam logic [2:0] FN_RETIRE  = 3'd4;
    localparam logic [2:0] FN_LK_HDL  = 3'd5;
    localparam logic [2:0] FN_LK_KEY  = 3'd6;

    // error codes
    localparam logic [3:0] ER_NONE      = 4'd0;
    localparam logic [3:0] ER_NULL      = 4'd1;
    localparam logic [3:0] ER_EMPTY     = 4'd2;
    localparam logic [3:0] ER_DUP       = 4'd3;
    localparam logic [3:0] ER_MISSING   = 4'd4;
    localparam logic [3:0] ER_STALE     = 4'd5;
    localparam logic [3:0] ER_IMMUTABLE = 4'd6;
    localparam logic [3:0] ER_RETIRING  = 4'd7;
    localparam logic [3:0] ER_REGRESS   = 4'd8;
    localparam logic [3:0] ER_EXHAUST   = 4'd9;
    localparam logic [3:0] ER_FULL      = 4'd10;

    // slot status codes
    localparam logic [1:0] ST_UNUSED   = 2'd0;
    localparam logic [1:0] ST_ALIVE    = 2'd1;
    localparam logic [1:0] ST_RETIRING = 2'd2;
    localparam logic [1:0] ST_FREED    = 2'd3;

    typedef struct packed {
        logic [2:0]  func;
        logic [47:0] address;
        logic [3:0]  kind;
        logic [1:0]  usage;
        logic [31:0] byte_size;
        logic [31:0] handle_generation;
        logic [47:0] timeline_value;
    } grt_req_t;

    typedef struct packed {
        logic [3:0]  error_code;
        logic [31:0] generation_out;
        logic        found;
        logic        entry_retiring;
        logic [1:0]  entry_usage;
        logic [31:0] entry_byte_size;
        logic [47:0] entry_last_use;
        logic [47:0] entry_retire_value;
        logic [6:0]  retired_count;
        logic [6:0]  alive_count;
        logic [6:0]  retiring_count;
    } grt_rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request, start scan
        logic scan;      // advance scan index
        logic read;      // read matched slot
        logic commit;    // evaluate and write back
        logic finish;    // build the response
    } grt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic is_retire;
    } grt_sts_t;

endpackage

@@ src/grt_datapath.sv @@
// ----------------------------------------------------------------------------
// grt_datapath
// Slot memory, key scan, retire sweep, status and counters.
// ----------------------------------------------------------------------------
module grt_datapath
    import grt_pkg::*;
#(
    parameter int unsigned ENTRIES       = ENTRIES_DEF,
    parameter int unsigned TIMELINE_BITS = TIMELINE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  grt_cmd_t    cmd,
    output grt_sts_t    sts,
    input  grt_req_t    req,
    input  logic [31:0] gen_limit,
    output grt_rsp_t    rsp
);

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    typedef struct packed {
        logic [47:0]              addr;
        logic [3:0]               kind;
        logic [31:0]              gen;
        logic [1:0]               usage;
        logic [31:0]              size;
        logic [TIMELINE_BITS-1:0] last;
        logic [TIMELINE_BITS-1:0] ret;
    } slot_t;

    // slot memory, status in flops
    slot_t      mem [ENTRIES];
    logic [1:0] status_reg [ENTRIES];

    grt_req_t                 req_reg;
    logic [IW-1:0]            idx_reg, idx_next;
    logic                     hit_reg;
    logic [IW-1:0]            hit_idx_reg;
    logic                     free_ok_reg;
    logic [IW-1:0]            free_idx_reg;
    slot_t                    rd_reg;
    logic [1:0]               rd_st_reg;
    logic [CW-1:0]            alive_reg, retg_reg, retired_reg;
    grt_rsp_t                 rsp_reg, rsp_next;
    logic [TIMELINE_BITS-1:0] tv;

    // registered scan read, compared in the cycle after the address
    slot_t                    cur_reg;
    logic [1:0]               cur_st_reg;
    logic [IW-1:0]            cur_idx_reg;
    logic                     cur_vld_reg;
    logic                     key_eq;
    logic                     sweep;

    assign tv = req_reg.timeline_value[TIMELINE_BITS-1:0];
    assign idx_next = idx_reg + IW'(1);
    assign sts.scan_last = (idx_reg == IW'(ENTRIES - 1));
    assign sts.is_retire = (req_reg.func == FN_RETIRE);
    assign rsp = rsp_reg;

    // key match and retire test on the slot read last cycle
    assign key_eq = (cur_st_reg != ST_UNUSED) && (cur_reg.addr == req_reg.address)
                    && (cur_reg.kind == req_reg.kind);
    assign sweep  = cur_vld_reg && sts.is_retire && cur_st_reg == ST_RETIRING
                    && cur_reg.ret <= tv;

    // scan read
    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            cur_reg     <= mem[idx_reg];
            cur_st_reg  <= status_reg[idx_reg];
            cur_idx_reg <= idx_reg;
        end
    end

    // scan bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            hit_reg      <= 1'b0;
            hit_idx_reg  <= '0;
            free_ok_reg  <= 1'b0;
            free_idx_reg <= '0;
            retired_reg  <= '0;
            cur_vld_reg  <= 1'b0;
        end
        else if (cmd.load)
        begin
            idx_reg     <= '0;
            hit_reg     <= 1'b0;
            free_ok_reg <= 1'b0;
            retired_reg <= '0;
            cur_vld_reg <= 1'b0;
        end
        else
        begin
            cur_vld_reg <= cmd.scan;
            if (cmd.scan)
                idx_reg <= idx_next;
            if (cur_vld_reg)
            begin
                if (key_eq && !hit_reg)
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= cur_idx_reg;
                end
                if (cur_st_reg == ST_UNUSED && !free_ok_reg)
                begin
                    free_ok_reg  <= 1'b1;
                    free_idx_reg <= cur_idx_reg;
                end
                if (sweep)
                    retired_reg <= retired_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
        if (cmd.read)
        begin
            rd_reg    <= mem[hit_idx_reg];
            rd_st_reg <= status_reg[hit_idx_reg];
        end
    end

    // evaluation of the operation on the read slot
    logic [3:0]  err;
    logic        wr_en, st_wr;
    logic [IW-1:0] wr_idx;
    slot_t       wr_data;
    logic [1:0]  wr_st;
    logic [31:0] gen_out;
    logic        show;
    logic        live;
    logic [31:0] lim;

    assign live = hit_reg && (rd_st_reg == ST_ALIVE || rd_st_reg == ST_RETIRING);
    assign lim  = (gen_limit == 32'd0) ? 32'd1 : gen_limit;

    always_comb
    begin
        err     = ER_NONE;
        wr_en   = 1'b0;
        st_wr   = 1'b0;
        wr_idx  = hit_idx_reg;
        wr_data = rd_reg;
        wr_st   = rd_st_reg;
        gen_out = 32'd0;
        show    = 1'b0;
        case (req_reg.func)
            FN_CREATE:
            begin
                if (req_reg.address == 48'd0)
                    err = ER_NULL;
                else if (req_reg.byte_size == 32'd0)
                    err = ER_EMPTY;
                else if (live)
                    err = ER_DUP;
                else if (hit_reg && rd_reg.gen >= lim)
                    err = ER_EXHAUST;
                else if (!hit_reg && !free_ok_reg)
                    err = ER_FULL;
                else
                begin
                    wr_en = 1'b1;
                    st_wr = 1'b1;
                    if (!hit_reg)
                    begin
                        wr_idx       = free_idx_reg;
                        wr_data.addr = req_reg.address;
                        wr_data.kind = req_reg.kind;
                        wr_data.gen  = 32'd1;
                    end
                    else
                        wr_data.gen = rd_reg.gen + 32'd1;
                    wr_st         = ST_ALIVE;
                    wr_data.usage = req_reg.usage;
                    wr_data.size  = req_reg.byte_size;
                    wr_data.last  = tv;
                    wr_data.ret   = '0;
                    gen_out       = wr_data.gen;
                end
            end
            FN_UPDATE, FN_TOUCH, FN_DESTROY:
            begin
                if (req_reg.address == 48'd0 || req_reg.handle_generation == 32'd0)
                    err = ER_MISSING;
                else if (!live)
                    err = (hit_reg && rd_reg.gen != req_reg.handle_generation)
                          ? ER_STALE : ER_MISSING;
                else if (rd_reg.gen != req_reg.handle_generation)
                    err = ER_STALE;
                else if (rd_st_reg == ST_RETIRING)
                    err = ER_RETIRING;
                else if (req_reg.func == FN_DESTROY)
                begin
                    st_wr       = 1'b1;
                    wr_en       = 1'b1;
                    wr_st       = ST_RETIRING;
                    wr_data.ret = (tv > rd_reg.last) ? tv : rd_reg.last;
                end
                else if (req_reg.func == FN_UPDATE && rd_reg.usage == 2'd0)
                    err = ER_IMMUTABLE;
                else if (req_reg.func == FN_UPDATE && req_reg.byte_size == 32'd0)
                    err = ER_EMPTY;
                else if (tv < rd_reg.last)
                    err = ER_REGRESS;
                else
                begin
                    wr_en        = 1'b1;
                    wr_data.last = tv;
                    if (req_reg.func == FN_UPDATE)
                        wr_data.size = req_reg.byte_size;
                end
            end
            FN_LK_HDL:
                show = live && (rd_reg.gen == req_reg.handle_generation);
            FN_LK_KEY:
                show = live;
            default:
                ;
        endcase
    end

    // memory write on commit; the retire sweep changes only the status flops
    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_en)
            mem[wr_idx] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                status_reg[i] <= ST_UNUSED;
            alive_reg <= '0;
            retg_reg  <= '0;
        end
        else if (sweep)
        begin
            status_reg[cur_idx_reg] <= ST_FREED;
            retg_reg                <= retg_reg - CW'(1);
        end
        else if (cmd.commit && st_wr)
        begin
            status_reg[wr_idx] <= wr_st;
            if (wr_st == ST_ALIVE)
                alive_reg <= alive_reg + CW'(1);
            else
            begin
                alive_reg <= alive_reg - CW'(1);
                retg_reg  <= retg_reg + CW'(1);
            end
        end
    end

    // response assembly
    always_comb
    begin
        rsp_next                = '0;
        rsp_next.error_code     = err;
        rsp_next.generation_out = show ? rd_reg.gen : gen_out;
        if (show)
        begin
            rsp_next.found           = 1'b1;
            rsp_next.entry_retiring  = (rd_st_reg == ST_RETIRING);
            rsp_next.entry_usage     = rd_reg.usage;
            rsp_next.entry_byte_size = rd_reg.size;
            rsp_next.entry_last_use  = 48'(rd_reg.last);
            rsp_next.entry_retire_value =
                (rd_st_reg == ST_RETIRING) ? 48'(rd_reg.ret) : 48'd0;
        end
        if (sts.is_retire)
            rsp_next.error_code = ER_NONE;
        rsp_next.retired_count = 7'(retired_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            rsp_reg <= rsp_next;
        if (cmd.finish)
        begin
            rsp_reg.alive_count    <= 7'(alive_reg);
            rsp_reg.retiring_count <= 7'(retg_reg);
        end
    end

endmodule

@@ src/grt_ctrl.sv @@
// ----------------------------------------------------------------------------
// grt_ctrl
// Sequencer: accept, scan the table, read, commit, present the result.
// ----------------------------------------------------------------------------
module grt_ctrl
    import grt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output grt_cmd_t cmd,
    input  grt_sts_t sts
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_DRAIN  = 7'b0000100,
        S_READ   = 7'b0001000,
        S_COMMIT = 7'b0010000,
        S_FINISH = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                    state_next = S_DRAIN;
            end
            // last slot read is checked here
            S_DRAIN:
                state_next = S_READ;
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
                if (!out_stall)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ src/generational_resource_table.sv @@
// ----------------------------------------------------------------------------
// generational_resource_table
// Table of generational resource handles with deferred free.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in        in   in_valid/in_stall  grt_req_t
//  out       out  out_valid/out_stall grt_rsp_t
//  cfg       in   cfg_valid/cfg_ready generation_limit (32 bits)
//
//  Each transaction scans the slots in turn for the key match and the retire
//  sweep, checks the last slot read, then reads the matched slot, commits,
//  builds the result, offers it on out until it is taken and returns to idle.
//  Reset marks every slot unused at once; no clearing pass.
//  A new request is taken only after the previous result has left.
// ----------------------------------------------------------------------------
module generational_resource_table
    import grt_pkg::*;
#(
    parameter int unsigned ENTRIES       = ENTRIES_DEF,
    parameter int unsigned TIMELINE_BITS = TIMELINE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  grt_req_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output grt_rsp_t    out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    grt_cmd_t    cmd;
    grt_sts_t    sts;
    logic [31:0] gen_limit_reg;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gen_limit_reg <= 32'hFFFF_FFFF;
        else if (cfg_valid)
            gen_limit_reg <= cfg_data;
    end

    grt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    grt_datapath #(
        .ENTRIES       (ENTRIES),
        .TIMELINE_BITS (TIMELINE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (in_data),
        .gen_limit (gen_limit_reg),
        .rsp       (out_data)
    );

endmodule
